// ===== src/sit_pkg.sv =====
// shared types and constants for the segment intersection test
package sit_pkg;

   localparam int LIMIT_W = 30;

   typedef enum logic [1:0] {
      ST_INTERSECT  = 2'd0,
      ST_NONE       = 2'd1,
      ST_PARALLEL   = 2'd2,
      ST_DEGENERATE = 2'd3
   } status_type;

endpackage

// ===== src/sit_front.sv =====
// front stages: differences, products, determinant and status decision, dividend products
module sit_front #(
   parameter int COORD_BITS      = 16,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic [3:0]                          en,
   input  logic signed [COORD_BITS-1:0]        req_first_start_x,
   input  logic signed [COORD_BITS-1:0]        req_first_start_y,
   input  logic signed [COORD_BITS-1:0]        req_first_end_x,
   input  logic signed [COORD_BITS-1:0]        req_first_end_y,
   input  logic signed [COORD_BITS-1:0]        req_second_start_x,
   input  logic signed [COORD_BITS-1:0]        req_second_start_y,
   input  logic signed [COORD_BITS-1:0]        req_second_end_x,
   input  logic signed [COORD_BITS-1:0]        req_second_end_y,
   input  logic [sit_pkg::LIMIT_W-1:0]         limit,
   output logic [2*COORD_BITS+3+(ALPHA_FRAC_BITS>COORD_BITS?ALPHA_FRAC_BITS:COORD_BITS):0]
                                               mx,
   output logic [2*COORD_BITS+3+(ALPHA_FRAC_BITS>COORD_BITS?ALPHA_FRAC_BITS:COORD_BITS):0]
                                               my,
   output logic [2*COORD_BITS+3+(ALPHA_FRAC_BITS>COORD_BITS?ALPHA_FRAC_BITS:COORD_BITS):0]
                                               ma,
   output logic [2*COORD_BITS+2:0]             dvsr,
   output logic [2*COORD_BITS+ALPHA_FRAC_BITS+5:0] side
);
   import sit_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = ALPHA_FRAC_BITS;
   localparam int DW = C + 1;
   localparam int PRW = 2 * C + 2;
   localparam int PW = 2 * C + 4;
   localparam int D  = 2 * C + 3;
   localparam int QB = (F > C ? F : C) + 1;
   localparam int W  = D + QB;
   localparam int SW = 2 * C + F + 6;
   localparam int CW = D > LIMIT_W ? D : LIMIT_W;

   // stage a: differences
   logic signed [DW-1:0] abx_ff, aby_ff, cdx_ff, cdy_ff, cax_ff, cay_ff;
   logic signed [C-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, dx_ff, dy_ff;
   logic                 degen_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         abx_ff <= DW'(req_first_end_x) - DW'(req_first_start_x);
         aby_ff <= DW'(req_first_end_y) - DW'(req_first_start_y);
         cdx_ff <= DW'(req_second_end_x) - DW'(req_second_start_x);
         cdy_ff <= DW'(req_second_end_y) - DW'(req_second_start_y);
         cax_ff <= DW'(req_first_start_x) - DW'(req_second_start_x);
         cay_ff <= DW'(req_first_start_y) - DW'(req_second_start_y);
         ax_ff <= req_first_start_x;
         ay_ff <= req_first_start_y;
         bx_ff <= req_first_end_x;
         by_ff <= req_first_end_y;
         cx_ff <= req_second_start_x;
         cy_ff <= req_second_start_y;
         dx_ff <= req_second_end_x;
         dy_ff <= req_second_end_y;
         degen_ff <= (req_first_start_x == req_first_end_x &&
                      req_first_start_y == req_first_end_y) ||
                     (req_second_start_x == req_second_end_x &&
                      req_second_start_y == req_second_end_y);
      end
   end

   // stage b: six products
   logic signed [PRW-1:0] p_abx_cdy_ff, p_aby_cdx_ff, p_cay_cdx_ff;
   logic signed [PRW-1:0] p_cax_cdy_ff, p_abx_cay_ff, p_aby_cax_ff;
   logic signed [DW-1:0]  abx_b_ff, aby_b_ff;
   logic signed [C-1:0]   ax_b_ff, ay_b_ff, bx_b_ff, by_b_ff, cx_b_ff, cy_b_ff;
   logic signed [C-1:0]   dx_b_ff, dy_b_ff;
   logic                  degen_b_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_abx_cdy_ff <= PRW'(abx_ff) * PRW'(cdy_ff);
         p_aby_cdx_ff <= PRW'(aby_ff) * PRW'(cdx_ff);
         p_cay_cdx_ff <= PRW'(cay_ff) * PRW'(cdx_ff);
         p_cax_cdy_ff <= PRW'(cax_ff) * PRW'(cdy_ff);
         p_abx_cay_ff <= PRW'(abx_ff) * PRW'(cay_ff);
         p_aby_cax_ff <= PRW'(aby_ff) * PRW'(cax_ff);
         abx_b_ff <= abx_ff;
         aby_b_ff <= aby_ff;
         ax_b_ff <= ax_ff;
         ay_b_ff <= ay_ff;
         bx_b_ff <= bx_ff;
         by_b_ff <= by_ff;
         cx_b_ff <= cx_ff;
         cy_b_ff <= cy_ff;
         dx_b_ff <= dx_ff;
         dy_b_ff <= dy_ff;
         degen_b_ff <= degen_ff;
      end
   end

   // stage c: determinant, numerators and the status decision
   logic signed [PW-1:0] det, n1, n2, detneg, n1neg;
   logic [D-1:0]         detm, n1m;
   logic                 par, outside, proper;
   status_type           st;
   logic signed [C-1:0]  px, py;
   logic [F:0]           alpha;

   always_comb begin
      det = PW'(p_abx_cdy_ff) - PW'(p_aby_cdx_ff);
      n1  = PW'(p_cay_cdx_ff) - PW'(p_cax_cdy_ff);
      n2  = PW'(p_abx_cay_ff) - PW'(p_aby_cax_ff);
      detneg = -det;
      n1neg  = -n1;
      detm = det[PW-1] ? detneg[D-1:0] : det[D-1:0];
      n1m  = n1[PW-1] ? n1neg[D-1:0] : n1[D-1:0];
      par  = CW'(detm) <= CW'(limit);
      if (!det[PW-1]) begin
         outside = n1 < 0 || n1 > det || n2 < 0 || n2 > det;
      end else begin
         outside = n1 > 0 || n1 < det || n2 > 0 || n2 < det;
      end
      st     = ST_INTERSECT;
      proper = 1'b0;
      px     = '0;
      py     = '0;
      alpha  = '0;
      priority if (degen_b_ff) begin
         st = ST_DEGENERATE;
      end else if (par) begin
         st = ST_PARALLEL;
      end else if (outside) begin
         st = ST_NONE;
      end else if (n1 == 0) begin
         px = ax_b_ff;
         py = ay_b_ff;
      end else if (n1 == det) begin
         px    = bx_b_ff;
         py    = by_b_ff;
         alpha = (F+1)'(1) << F;
      end else if (n2 == 0) begin
         px = cx_b_ff;
         py = cy_b_ff;
      end else if (n2 == det) begin
         px    = dx_b_ff;
         py    = dy_b_ff;
         alpha = (F+1)'(1) << F;
      end else begin
         // proper crossing: base point a, offsets come from the divider
         proper = 1'b1;
         px     = ax_b_ff;
         py     = ay_b_ff;
      end
   end

   logic [D-1:0]         detm_ff, n1m_ff;
   logic signed [DW-1:0] abx_c_ff, aby_c_ff;
   logic [SW-3:0]        side_c_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         detm_ff   <= detm;
         n1m_ff    <= n1m;
         abx_c_ff  <= abx_b_ff;
         aby_c_ff  <= aby_b_ff;
         side_c_ff <= {st, proper, px, py, alpha};
      end
   end

   // stage d: dividends for the three quotients
   logic signed [DW-1:0] abxn, abyn;
   logic [DW-1:0]        absx, absy;

   always_comb begin
      abxn = -abx_c_ff;
      abyn = -aby_c_ff;
      absx = abx_c_ff[DW-1] ? abxn : abx_c_ff;
      absy = aby_c_ff[DW-1] ? abyn : aby_c_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         mx   <= W'(absx) * W'(n1m_ff);
         my   <= W'(absy) * W'(n1m_ff);
         ma   <= W'(n1m_ff) << F;
         dvsr <= detm_ff;
         side <= {side_c_ff, abx_c_ff[DW-1], aby_c_ff[DW-1]};
      end
   end

endmodule

// ===== src/sit_div_cell.sv =====
// one restoring division step for three quotient lanes sharing one divisor
module sit_div_cell #(
   parameter int W     = 57,
   parameter int D     = 35,
   parameter int QB    = 17,
   parameter int SW    = 55,
   parameter int SHIFT = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2:0][W-1:0]     rem_i,
   input  logic [2:0][QB-1:0]    quo_i,
   input  logic [D-1:0]          dvsr_i,
   input  logic [SW-1:0]         side_i,
   output logic [2:0][W-1:0]     rem_o,
   output logic [2:0][QB-1:0]    quo_o,
   output logic [D-1:0]          dvsr_o,
   output logic [SW-1:0]         side_o
);
   logic [W-1:0]          step;
   logic [2:0][W-1:0]     rem_in;
   logic [2:0][QB-1:0]    quo_in;

   always_comb begin
      step = W'(dvsr_i) << SHIFT;
      for (int k = 0; k < 3; k++) begin
         rem_in[k] = rem_i[k];
         quo_in[k] = quo_i[k];
         if (rem_i[k] >= step) begin
            rem_in[k]        = rem_i[k] - step;
            quo_in[k][SHIFT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_o  <= rem_in;
         quo_o  <= quo_in;
         dvsr_o <= dvsr_i;
         side_o <= side_i;
      end
   end

endmodule

// ===== src/segment_intersection_test.sv =====
// segment intersection test: top level with handshake, divider cell chain and output stage
//
// Input channel req_*: one word holds two segments a-b and c-d. A word is taken
// at a clock edge with req_valid high and req_stall low. Result channel rsp_*:
// one word per input word, in order, with status, point and alpha fraction.
// The chain holds 4 + max(COORD_BITS, ALPHA_FRAC_BITS) + 2 registers (22 at the
// defaults): four front stages (differences, products, determinant and decision,
// dividend products), one restoring division cell per quotient bit, and the
// output register. Throughput is one word per cycle while rsp_stall is low;
// every stage advances whenever its successor is empty or moving, so bubbles
// close up while rsp_stall is high and the block keeps taking words until the
// whole chain is full.
// csr_write_enable with csr_write_data sets the parallel limit (reset value 1).
// A synchronous reset empties the chain and restores the limit; req_stall is
// high during reset, so no word is taken then.
module segment_intersection_test #(
   parameter int COORD_BITS      = 16,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_first_start_x,
   input  logic signed [COORD_BITS-1:0]  req_first_start_y,
   input  logic signed [COORD_BITS-1:0]  req_first_end_x,
   input  logic signed [COORD_BITS-1:0]  req_first_end_y,
   input  logic signed [COORD_BITS-1:0]  req_second_start_x,
   input  logic signed [COORD_BITS-1:0]  req_second_start_y,
   input  logic signed [COORD_BITS-1:0]  req_second_end_x,
   input  logic signed [COORD_BITS-1:0]  req_second_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic signed [COORD_BITS-1:0]  rsp_cross_x,
   output logic signed [COORD_BITS-1:0]  rsp_cross_y,
   output logic [ALPHA_FRAC_BITS:0]      rsp_alpha_fraction,
   input  logic                          csr_write_enable,
   input  logic [sit_pkg::LIMIT_W-1:0]   csr_write_data
);
   import sit_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = ALPHA_FRAC_BITS;
   localparam int D  = 2 * C + 3;
   localparam int QB = (F > C ? F : C) + 1;
   localparam int W  = D + QB;
   localparam int SW = 2 * C + F + 6;
   localparam int S  = 4 + QB + 1;

   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(1);
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // per-stage occupancy and advance
   logic [S-1:0] v_ff;
   logic [S:0]   en;

   assign en[S] = !rsp_stall;
   for (genvar k = 0; k < S; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = reset || !en[0];

   logic [W-1:0]  f_mx, f_my, f_ma;
   logic [D-1:0]  f_dvsr;
   logic [SW-1:0] f_side;

   sit_front #(.COORD_BITS(C), .ALPHA_FRAC_BITS(F)) u_front (
      .clock              (clock),
      .en                 (en[3:0]),
      .req_first_start_x  (req_first_start_x),
      .req_first_start_y  (req_first_start_y),
      .req_first_end_x    (req_first_end_x),
      .req_first_end_y    (req_first_end_y),
      .req_second_start_x (req_second_start_x),
      .req_second_start_y (req_second_start_y),
      .req_second_end_x   (req_second_end_x),
      .req_second_end_y   (req_second_end_y),
      .limit              (limit_ff),
      .mx                 (f_mx),
      .my                 (f_my),
      .ma                 (f_ma),
      .dvsr               (f_dvsr),
      .side               (f_side)
   );

   logic [2:0][W-1:0]  rem_w  [QB+1];
   logic [2:0][QB-1:0] quo_w  [QB+1];
   logic [D-1:0]       dvsr_w [QB+1];
   logic [SW-1:0]      side_w [QB+1];

   assign rem_w[0]  = {f_ma, f_my, f_mx};
   assign quo_w[0]  = '0;
   assign dvsr_w[0] = f_dvsr;
   assign side_w[0] = f_side;

   // quotient bits from the top down, one cell each
   for (genvar i = 0; i < QB; i++) begin : g_cell
      sit_div_cell #(
         .W(W), .D(D), .QB(QB), .SW(SW), .SHIFT(QB - 1 - i)
      ) u_cell (
         .clock  (clock),
         .en     (en[4+i]),
         .rem_i  (rem_w[i]),
         .quo_i  (quo_w[i]),
         .dvsr_i (dvsr_w[i]),
         .side_i (side_w[i]),
         .rem_o  (rem_w[i+1]),
         .quo_o  (quo_w[i+1]),
         .dvsr_o (dvsr_w[i+1]),
         .side_o (side_w[i+1])
      );
   end

   // output stage
   logic [1:0]          o_st;
   logic                o_proper, o_sx, o_sy;
   logic signed [C-1:0] o_px, o_py;
   logic [F:0]          o_alpha;
   logic [C:0]          qx, qy, offx, offy, sumx, sumy;
   logic [1:0]          st_in;
   logic [C-1:0]        x_in, y_in;
   logic [F:0]          a_in;

   always_comb begin
      {o_st, o_proper, o_px, o_py, o_alpha, o_sx, o_sy} = side_w[QB];
      qx   = quo_w[QB][0][C:0];
      qy   = quo_w[QB][1][C:0];
      offx = o_sx ? -qx : qx;
      offy = o_sy ? -qy : qy;
      sumx = (C+1)'(o_px) + offx;
      sumy = (C+1)'(o_py) + offy;
      st_in = o_st;
      if (o_proper) begin
         x_in = sumx[C-1:0];
         y_in = sumy[C-1:0];
         a_in = quo_w[QB][2][F:0];
      end else begin
         x_in = o_px;
         y_in = o_py;
         a_in = o_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S-1]) begin
         rsp_status         <= st_in;
         rsp_cross_x        <= x_in;
         rsp_cross_y        <= y_in;
         rsp_alpha_fraction <= a_in;
      end
   end

   assign rsp_valid = v_ff[S-1];

   a_zero_unless_intersect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_INTERSECT |->
         rsp_cross_x == 0 && rsp_cross_y == 0 && rsp_alpha_fraction == 0)
      else $error("non-intersect word carries a point");

   a_alpha_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alpha_fraction <= ((F+1)'(1) << F))
      else $error("alpha above one");

   a_empty_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall with empty output stage");

endmodule
